>>> hdl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared widths, constants and saturation helpers for the refraction unit.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int COMP_W        = 16;
  localparam int INDEX_W       = 16;

  localparam logic [INDEX_W-1:0] OUTER_RESET = 16'd4096;

  localparam logic signed [63:0] LIM       = 64'sh7FFF_FFFF;
  localparam logic [30:0]        RATIO_MAX = 31'h7FFF_FFFF;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > LIM) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -LIM) begin
      r = -32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/rrd_if.sv
// ----------------------------------------------------------------------------
// rrd_if
// Item channels of the refraction unit: ray in, new direction out.
// ----------------------------------------------------------------------------
interface rrd_ray_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        dir_x;
  logic signed [15:0]        dir_y;
  logic signed [15:0]        dir_z;
  logic signed [15:0]        norm_x;
  logic signed [15:0]        norm_y;
  logic signed [15:0]        norm_z;
  logic [15:0]               material_index;

  modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                  material_index, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                  material_index, output ready);
endinterface

interface rrd_dir_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               total_internal;

  modport source (output valid, out_x, out_y, out_z, total_internal, input ready);
  modport sink   (input valid, out_x, out_y, out_z, total_internal, output ready);
endinterface

>>> hdl/ray_refraction_direction_unit.sv
// ----------------------------------------------------------------------------
// ray_refraction_direction_unit
// Snell refraction of a unit ray direction at a surface, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   ray    : valid/ready channel with the direction, the normal (Q2.14) and
//            the hit material's index (Q4.12). One item per accepted cycle.
//   result : valid/ready channel with the new direction, saturated, and
//            total_internal set when the mirror direction is returned.
//   cfg_write / cfg_data set the outer medium index (Q4.12); write it only
//   while no item is in flight.
// Throughput: one item per cycle while the output is not stalled (see Stall), every item independent.
// Pipeline: five front stages, a 16 + FRAC_BITS stage divider for the
//   index ratio, five product stages, a 32 stage square root, two final
//   stages and the output register.
// Reset: clears all valid bits; outer index returns to 1.0.
// Stall: the output holds two items (register plus skid); while both are
//   full and result.ready is low the whole pipeline and ray.ready stop, and
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_refraction_direction_unit #(
  parameter int FRAC_BITS = rrd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rrd_pkg::INDEX_W-1:0] cfg_data,
  rrd_ray_if.sink                     ray,
  rrd_dir_if.source                   result
);

  localparam int F   = FRAC_BITS;
  localparam int CW  = 32 - F;
  localparam int DW  = 16 + F;
  localparam int RCW = 31 + CW - F;
  localparam int RDW = 48 - F;
  localparam logic signed [63:0] ONE = 64'sd1 <<< F;

  localparam int SIDE1_W = 48 + 48 + 1 + CW + 32 + 48;
  localparam int SIDE2_W = 1 + 48 + 51 + RCW + 3 * RDW;

  logic adv;
  logic push;

  // configuration
  logic [15:0] outer;
  always_ff @(posedge clk) begin
    if (rst) begin
      outer <= rrd_pkg::OUTER_RESET;
    end else if (cfg_write) begin
      outer <= cfg_data;
    end
  end

  // P1: component products
  logic               a_vld;
  logic signed [15:0] a_d [3];
  logic signed [15:0] a_n [3];
  logic signed [31:0] a_p [3];
  logic [15:0]        a_mat;
  logic [15:0]        a_outer;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= ray.valid;
    end
    if (adv) begin
      a_d[0]  <= ray.dir_x;
      a_d[1]  <= ray.dir_y;
      a_d[2]  <= ray.dir_z;
      a_n[0]  <= ray.norm_x;
      a_n[1]  <= ray.norm_y;
      a_n[2]  <= ray.norm_z;
      a_p[0]  <= ray.dir_x * ray.norm_x;
      a_p[1]  <= ray.dir_y * ray.norm_y;
      a_p[2]  <= ray.dir_z * ray.norm_z;
      a_mat   <= ray.material_index;
      a_outer <= outer;
    end
  end

  // P2: dot product
  logic               b_vld;
  logic signed [32:0] b_dot;
  logic signed [15:0] b_d [3];
  logic signed [15:0] b_n [3];
  logic [15:0]        b_mat;
  logic [15:0]        b_outer;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
    if (adv) begin
      b_dot   <= 33'(a_p[0]) + 33'(a_p[1]) + 33'(a_p[2]);
      b_d     <= a_d;
      b_n     <= a_n;
      b_mat   <= a_mat;
      b_outer <= a_outer;
    end
  end

  // P3: side of the surface, cosine, ratio operands, mirror products
  logic               b_ent;
  logic [32:0]        b_mag;
  logic [15:0]        b_den;
  logic               c_vld;
  logic               c_ent;
  logic [CW-1:0]      c_c;
  logic [15:0]        c_num;
  logic [15:0]        c_den;
  logic signed [15:0] c_d [3];
  logic signed [15:0] c_n [3];
  logic signed [48:0] c_rp [3];

  assign b_ent = b_dot[32];
  assign b_mag = b_ent ? -b_dot : b_dot;
  assign b_den = b_ent ? b_mat : b_outer;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
    if (adv) begin
      c_ent   <= b_ent;
      c_c     <= b_mag[31:F];
      c_num   <= b_ent ? b_outer : b_mat;
      c_den   <= (b_den == 16'd0) ? 16'd1 : b_den;
      c_d     <= b_d;
      c_n     <= b_n;
      for (int i = 0; i < 3; i++) begin
        c_rp[i] <= b_dot * b_n[i];
      end
    end
  end

  // P4: cosine squared, mirror direction
  logic               d_vld;
  logic               d_ent;
  logic [2*CW-1:0]    d_cc;
  logic [CW-1:0]      d_c;
  logic [15:0]        d_num;
  logic [15:0]        d_den;
  logic signed [15:0] d_d [3];
  logic signed [15:0] d_n [3];
  logic signed [15:0] d_refl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
    if (adv) begin
      d_ent <= c_ent;
      d_cc  <= c_c * c_c;
      d_c   <= c_c;
      d_num <= c_num;
      d_den <= c_den;
      d_d   <= c_d;
      d_n   <= c_n;
      for (int i = 0; i < 3; i++) begin
        d_refl[i] <= rrd_pkg::sat16(64'(c_d[i]) - (64'(c_rp[i]) >>> (2 * F - 1)));
      end
    end
  end

  // P5: sine squared
  logic               e_vld;
  logic               e_ent;
  logic signed [31:0] e_s;
  logic [CW-1:0]      e_c;
  logic [15:0]        e_num;
  logic [15:0]        e_den;
  logic signed [15:0] e_d [3];
  logic signed [15:0] e_n [3];
  logic signed [15:0] e_refl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
    if (adv) begin
      e_ent  <= d_ent;
      e_s    <= rrd_pkg::sat32(ONE - $signed(64'(d_cc >> F)));
      e_c    <= d_c;
      e_num  <= d_num;
      e_den  <= d_den;
      e_d    <= d_d;
      e_n    <= d_n;
      e_refl <= d_refl;
    end
  end

  // index ratio
  logic               v_vld;
  logic [DW-1:0]      v_q;
  logic [SIDE1_W-1:0] v_side;
  logic signed [15:0] v_d [3];
  logic signed [15:0] v_n [3];
  logic               v_ent;
  logic [CW-1:0]      v_c;
  logic signed [31:0] v_s;
  logic signed [15:0] v_refl [3];

  rrd_divider #(
    .DVD_W  (DW),
    .SIDE_W (SIDE1_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_vld),
    .dividend  ({e_num, {F{1'b0}}}),
    .divisor   (e_den),
    .side_in   ({e_d[0], e_d[1], e_d[2], e_n[0], e_n[1], e_n[2], e_ent, e_c, e_s,
                 e_refl[0], e_refl[1], e_refl[2]}),
    .out_valid (v_vld),
    .quotient  (v_q),
    .side_out  (v_side)
  );

  assign {v_d[0], v_d[1], v_d[2], v_n[0], v_n[1], v_n[2], v_ent, v_c, v_s,
          v_refl[0], v_refl[1], v_refl[2]} = v_side;

  // Q1: ratio clamp
  logic               f_vld;
  logic [30:0]        f_ratio;
  logic               f_ent;
  logic [CW-1:0]      f_c;
  logic signed [31:0] f_s;
  logic signed [15:0] f_d [3];
  logic signed [15:0] f_n [3];
  logic signed [15:0] f_refl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= v_vld;
    end
    if (adv) begin
      f_ratio <= (64'(v_q) > 64'(rrd_pkg::LIM)) ? rrd_pkg::RATIO_MAX : 31'(v_q);
      f_ent   <= v_ent;
      f_c     <= v_c;
      f_s     <= v_s;
      f_d     <= v_d;
      f_n     <= v_n;
      f_refl  <= v_refl;
    end
  end

  // Q2: ratio products, oriented normal
  logic               g_vld;
  logic [61:0]        g_rr;
  logic [31+CW-1:0]   g_rc;
  logic signed [47:0] g_rdp [3];
  logic signed [16:0] g_m [3];
  logic signed [31:0] g_s;
  logic signed [15:0] g_refl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= f_vld;
    end
    if (adv) begin
      g_rr <= f_ratio * f_ratio;
      g_rc <= f_ratio * f_c;
      for (int i = 0; i < 3; i++) begin
        g_rdp[i] <= $signed({1'b0, f_ratio}) * f_d[i];
        g_m[i]   <= f_ent ? 17'(f_n[i]) : -17'(f_n[i]);
      end
      g_s    <= f_s;
      g_refl <= f_refl;
    end
  end

  // Q3: reductions
  logic [61:0]          g_rr_sh;
  logic                 h_vld;
  logic [30:0]          h_nsq;
  logic [RCW-1:0]       h_rc;
  logic signed [RDW-1:0] h_rd [3];
  logic signed [16:0]   h_m [3];
  logic signed [31:0]   h_s;
  logic signed [15:0]   h_refl [3];

  assign g_rr_sh = g_rr >> F;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= g_vld;
    end
    if (adv) begin
      h_nsq <= (g_rr_sh > 62'(rrd_pkg::RATIO_MAX)) ? rrd_pkg::RATIO_MAX : g_rr_sh[30:0];
      h_rc  <= RCW'(g_rc >> F);
      for (int i = 0; i < 3; i++) begin
        h_rd[i] <= RDW'(g_rdp[i] >>> F);
      end
      h_m    <= g_m;
      h_s    <= g_s;
      h_refl <= g_refl;
    end
  end

  // Q4: ratio squared times sine squared
  logic                  j_vld;
  logic signed [63:0]    j_kp;
  logic [RCW-1:0]        j_rc;
  logic signed [RDW-1:0] j_rd [3];
  logic signed [16:0]    j_m [3];
  logic signed [15:0]    j_refl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (adv) begin
      j_vld <= h_vld;
    end
    if (adv) begin
      j_kp   <= $signed({1'b0, h_nsq}) * h_s;
      j_rc   <= h_rc;
      j_rd   <= h_rd;
      j_m    <= h_m;
      j_refl <= h_refl;
    end
  end

  // Q5: k, reflection decision, radicand
  logic signed [63:0]    j_k;
  logic                  k_vld;
  logic                  k_tir;
  logic [63:0]           k_rad;
  logic [RCW-1:0]        k_rc;
  logic signed [RDW-1:0] k_rd [3];
  logic signed [16:0]    k_m [3];
  logic signed [15:0]    k_refl [3];

  assign j_k = ONE - (j_kp >>> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (adv) begin
      k_vld <= j_vld;
    end
    if (adv) begin
      k_tir  <= j_k[63];
      k_rad  <= j_k[63] ? 64'd0 : (64'(j_k) << F);
      k_rc   <= j_rc;
      k_rd   <= j_rd;
      k_m    <= j_m;
      k_refl <= j_refl;
    end
  end

  // square root
  logic                  u_vld;
  logic [31:0]           u_root;
  logic [SIDE2_W-1:0]    u_side;
  logic                  u_tir;
  logic signed [15:0]    u_refl [3];
  logic signed [16:0]    u_m [3];
  logic [RCW-1:0]        u_rc;
  logic signed [RDW-1:0] u_rd [3];

  rrd_sqrt #(
    .SIDE_W (SIDE2_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (k_vld),
    .radicand  (k_rad),
    .side_in   ({k_tir, k_refl[0], k_refl[1], k_refl[2], k_m[0], k_m[1], k_m[2], k_rc,
                 k_rd[0], k_rd[1], k_rd[2]}),
    .out_valid (u_vld),
    .root      (u_root),
    .side_out  (u_side)
  );

  assign {u_tir, u_refl[0], u_refl[1], u_refl[2], u_m[0], u_m[1], u_m[2], u_rc,
          u_rd[0], u_rd[1], u_rd[2]} = u_side;

  // R1: normal coefficient
  logic                  l_vld;
  logic signed [31:0]    l_coef;
  logic                  l_tir;
  logic signed [15:0]    l_refl [3];
  logic signed [16:0]    l_m [3];
  logic signed [RDW-1:0] l_rd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld <= 1'b0;
    end else if (adv) begin
      l_vld <= u_vld;
    end
    if (adv) begin
      l_coef <= rrd_pkg::sat32($signed(64'(u_rc)) - $signed(64'(u_root)));
      l_tir  <= u_tir;
      l_refl <= u_refl;
      l_m    <= u_m;
      l_rd   <= u_rd;
    end
  end

  // R2: coefficient times normal
  logic                  m_vld;
  logic signed [48:0]    m_cm [3];
  logic                  m_tir;
  logic signed [15:0]    m_refl [3];
  logic signed [RDW-1:0] m_rd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= l_vld;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_cm[i] <= l_coef * l_m[i];
      end
      m_tir  <= l_tir;
      m_refl <= l_refl;
      m_rd   <= l_rd;
    end
  end

  // R3: final sum and choice, into output register
  logic signed [15:0] fin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = m_tir ? m_refl[i]
                     : rrd_pkg::sat16(64'(m_rd[i]) + (64'(m_cm[i]) >>> F));
    end
  end

  logic               hd_vld;
  logic signed [15:0] hd [3];
  logic               hd_tir;
  logic               sk_vld;
  logic signed [15:0] sk [3];
  logic               sk_tir;
  logic               pop;

  assign pop  = hd_vld && result.ready;
  assign adv  = !(hd_vld && sk_vld) || result.ready;
  assign push = adv && m_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      hd_vld <= 1'b0;
      sk_vld <= 1'b0;
    end else if (pop || !hd_vld) begin
      hd_vld <= sk_vld || push;
      sk_vld <= sk_vld && push;
    end else if (push) begin
      sk_vld <= 1'b1;
    end
    if (pop || !hd_vld) begin
      if (sk_vld) begin
        hd     <= sk;
        hd_tir <= sk_tir;
        sk     <= fin;
        sk_tir <= m_tir;
      end else begin
        hd     <= fin;
        hd_tir <= m_tir;
      end
    end else if (push) begin
      sk     <= fin;
      sk_tir <= m_tir;
    end
  end

  assign ray.ready             = adv;
  assign result.valid          = hd_vld;
  assign result.out_x          = hd[0];
  assign result.out_y          = hd[1];
  assign result.out_z          = hd[2];
  assign result.total_internal = hd_tir;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    sk_vld |-> hd_vld)
    else $error("skid item without head item");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (hd_vld && sk_vld && !result.ready) |-> !push)
    else $error("item pushed into full output stage");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (sk_vld && !result.ready) |=> sk_vld)
    else $error("waiting skid item dropped");

endmodule

>>> hdl/rrd_divider.sv
// ----------------------------------------------------------------------------
// rrd_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rrd_divider #(
  parameter int DVD_W  = 30,
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [rrd_pkg::INDEX_W-1:0] divisor,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [DVD_W-1:0]            quotient,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int DV = rrd_pkg::INDEX_W;

  logic              vld  [DVD_W];
  logic [DV-1:0]     rem  [DVD_W];
  logic [DVD_W-1:0]  sh   [DVD_W];
  logic [DV-1:0]     den  [DVD_W];
  logic [SIDE_W-1:0] side [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic              src_vld;
    logic [DV-1:0]     src_rem;
    logic [DVD_W-1:0]  src_sh;
    logic [DV-1:0]     src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DV:0]       trial;
    logic [DV:0]       diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_sh   = dividend;
      assign src_den  = divisor;
      assign src_side = side_in;
    end else begin : g_next
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_sh   = sh[k-1];
      assign src_den  = den[k-1];
      assign src_side = side[k-1];
    end

    assign trial = {src_rem, src_sh[DVD_W-1]};
    assign ge    = trial >= {1'b0, src_den};
    assign diff  = trial - {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_vld;
      end
      if (en) begin
        rem[k]  <= ge ? diff[DV-1:0] : trial[DV-1:0];
        sh[k]   <= {src_sh[DVD_W-2:0], ge};
        den[k]  <= src_den;
        side[k] <= src_side;
      end
    end
  end

  assign out_valid = vld[DVD_W-1];
  assign quotient  = sh[DVD_W-1];
  assign side_out  = side[DVD_W-1];

endmodule

>>> hdl/rrd_sqrt.sv
// ----------------------------------------------------------------------------
// rrd_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module rrd_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STAGES = 32;

  logic              vld  [STAGES];
  logic [32:0]       rem  [STAGES];
  logic [31:0]       rt   [STAGES];
  logic [63:0]       rad  [STAGES];
  logic [SIDE_W-1:0] side [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              src_vld;
    logic [32:0]       src_rem;
    logic [31:0]       src_rt;
    logic [63:0]       src_rad;
    logic [SIDE_W-1:0] src_side;
    logic [33:0]       t_rem;
    logic [33:0]       trial;
    logic [33:0]       diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_rt   = '0;
      assign src_rad  = radicand;
      assign src_side = side_in;
    end else begin : g_next
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_rt   = rt[k-1];
      assign src_rad  = rad[k-1];
      assign src_side = side[k-1];
    end

    assign t_rem = {src_rem[31:0], src_rad[63:62]};
    assign trial = {src_rt, 2'b01};
    assign ge    = t_rem >= trial;
    assign diff  = t_rem - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_vld;
      end
      if (en) begin
        rem[k]  <= ge ? diff[32:0] : t_rem[32:0];
        rt[k]   <= {src_rt[30:0], ge};
        rad[k]  <= {src_rad[61:0], 2'b00};
        side[k] <= src_side;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign root      = rt[STAGES-1];
  assign side_out  = side[STAGES-1];

endmodule
